[rtl/polyline_path_follower_defines.svh]
// ----------------------------------------------------------------------------
// Polyline path follower assertion macros
// Shared helpers for concurrent checks clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_PATH_FOLLOWER_DEFINES_SVH
`define POLYLINE_PATH_FOLLOWER_DEFINES_SVH

// check that a condition holds at every clock edge
`define PPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies another at the same edge
`define PPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/ppf_pkg.sv]
// ----------------------------------------------------------------------------
// Polyline path follower package
// Command codes, waypoint type and fixed-point thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppf_pkg;

  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_SETPOS = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_CANCEL = 3'd4;

  // 0.02 in Q16.16
  localparam logic [32:0] SNAP_DIST   = 33'd1311;
  // 1e-6 in Q32.32
  localparam logic [32:0] FACE_EPS_SQ = 33'd4295;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } wp_t;

endpackage

[rtl/polyline_path_follower.sv]
// ----------------------------------------------------------------------------
// Polyline path follower
// Moves a point along a list of 3D waypoints in signed Q16.16.
// ----------------------------------------------------------------------------
// Input channel s_axis carries one command item: the command code on tuser
// (start path, append waypoint, set position, move tick or cancel) and the
// coordinates, speed and time on tdata. Output channel m_axis returns exactly
// one status item per command: position, facing target and path status.
// Start, append, set position, cancel and unknown codes go straight to the
// done state, which raises m_axis_tvalid_o. A move tick first forms its step
// budget, then per waypoint squares the differences on one shared 32x32
// multiplier and takes a one-bit-per-cycle square root of 32 steps. A
// waypoint near enough is snapped to; else the facing is tested, and the
// waypoint is reached if the budget covers it, or else a partial advance
// runs three multiplies, each followed by a 32-step restoring divide. All
// multiplies run through that one multiplier under the sequencer;
// s_axis_tready_o is high only in idle, so each command waits for the last.
// A finished item waits in the output register; the next command may be
// accepted meanwhile, and its result is held until m_axis_tready_i frees it,
// with s_axis_tready_o low meanwhile.
// Reset empties the path, zeroes the position and facing target. The
// waypoint memory is not cleared; entries are read only below the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polyline_path_follower_defines.svh"

module polyline_path_follower #(
  parameter int MAX_WAYPOINTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // coord_x[31:0], coord_y[63:32], coord_z[95:64], move_speed[127:96],
  // time_delta[143:128]
  input  logic [143:0] s_axis_tdata_i,
  // command[2:0]
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], face_x[127:96], face_z[159:128],
  // face_valid[160], path_active[161], next_slot[168:162],
  // store_overflow[169], zero[175:170]
  output logic [175:0] m_axis_tdata_o
);

  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_BUDGET = 5'd1;
  localparam logic [4:0] S_LOOP   = 5'd2;
  localparam logic [4:0] S_DIFF   = 5'd3;
  localparam logic [4:0] S_SQA    = 5'd4;
  localparam logic [4:0] S_SQB    = 5'd5;
  localparam logic [4:0] S_SQC    = 5'd6;
  localparam logic [4:0] S_SQD    = 5'd7;
  localparam logic [4:0] S_ROOT   = 5'd8;
  localparam logic [4:0] S_SNAP   = 5'd9;
  localparam logic [4:0] S_FACEA  = 5'd10;
  localparam logic [4:0] S_FACEB  = 5'd11;
  localparam logic [4:0] S_PMUL   = 5'd12;
  localparam logic [4:0] S_PDIVI  = 5'd13;
  localparam logic [4:0] S_PDIV   = 5'd14;
  localparam logic [4:0] S_PAPPLY = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0] state_q, state_d;

  logic [2:0]  in_cmd;
  ppf_pkg::wp_t in_wp;
  logic [31:0] in_speed;
  logic [15:0] in_dt;
  logic        in_acc;

  assign in_cmd   = s_axis_tuser_i;
  assign in_wp.x  = s_axis_tdata_i[31:0];
  assign in_wp.y  = s_axis_tdata_i[63:32];
  assign in_wp.z  = s_axis_tdata_i[95:64];
  assign in_speed = s_axis_tdata_i[127:96];
  assign in_dt    = s_axis_tdata_i[143:128];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  logic [CW-1:0] count_q, next_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] face_x_q, face_z_q;
  logic        fvalid_q, ovf_q;

  logic [31:0] rem_q;
  logic [31:0] mag_q [3];
  logic        neg_q [3];
  logic [31:0] sq_q  [3];
  logic        shift_q;
  logic [63:0] prod_q, n_q, r_q, bit_q;
  logic [32:0] dist_q;
  logic [4:0]  cnt_q;
  logic [1:0]  axis_q;
  logic [32:0] div_r_q;
  logic [31:0] div_lo_q, quo_q;

  logic           out_valid_q;
  logic [175:0]   out_data_q;

  // waypoint memory
  logic          wp_we;
  logic [AW-1:0] wp_waddr;
  ppf_pkg::wp_t  wp_rd;
  logic          count_full;

  assign count_full = (count_q >= CW'(MAX_WAYPOINTS));
  assign wp_we = in_acc && ((in_cmd == ppf_pkg::CMD_START) ||
                            ((in_cmd == ppf_pkg::CMD_APPEND) && !count_full));
  assign wp_waddr = (in_cmd == ppf_pkg::CMD_START) ? '0 : count_q[AW-1:0];

  ppf_wp_store #(
    .DEPTH (MAX_WAYPOINTS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wp_we),
    .waddr_i (wp_waddr),
    .wdata_i (in_wp),
    .raddr_i (next_q[AW-1:0]),
    .rdata_o (wp_rd)
  );

  // differences to the current target
  logic signed [32:0] diff [3];
  logic [32:0]        dmag [3];
  logic [31:0]        tgt  [3];
  assign tgt[0] = wp_rd.x;
  assign tgt[1] = wp_rd.y;
  assign tgt[2] = wp_rd.z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({tgt[k][31], tgt[k]}) - $signed({pos_q[k][31], pos_q[k]});
      dmag[k] = diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
    end
  end

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_IDLE:  begin mul_a = in_speed;  mul_b = {16'd0, in_dt}; end
      S_SQA:   begin mul_a = sq_q[0];   mul_b = sq_q[0]; end
      S_SQB:   begin mul_a = sq_q[1];   mul_b = sq_q[1]; end
      S_SQC:   begin mul_a = sq_q[2];   mul_b = sq_q[2]; end
      S_SNAP:  begin mul_a = {16'd0, mag_q[0][15:0]}; mul_b = {16'd0, mag_q[0][15:0]}; end
      S_FACEA: begin mul_a = {16'd0, mag_q[2][15:0]}; mul_b = {16'd0, mag_q[2][15:0]}; end
      S_PMUL:  begin mul_a = mag_q[axis_q]; mul_b = rem_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  logic [63:0] root_sum;
  logic [32:0] dist_now;
  logic [32:0] face_sum;
  logic        face_hit;
  logic [33:0] div_try;
  logic        div_ge;

  assign root_sum = r_q + bit_q;
  assign dist_now = {1'b0, r_q[31:0]} << shift_q;
  assign face_sum = {1'b0, n_q[31:0]} + {1'b0, prod_q[31:0]};
  assign face_hit = (mag_q[0] >= 32'h10000) || (mag_q[2] >= 32'h10000) ||
                    (face_sum > ppf_pkg::FACE_EPS_SQ);
  assign div_try  = {div_r_q, div_lo_q[31]};
  assign div_ge   = (div_try >= {1'b0, dist_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = (in_cmd == ppf_pkg::CMD_TICK) ? S_BUDGET : S_DONE;
      S_BUDGET: state_d = S_LOOP;
      S_LOOP:   state_d = ((rem_q != '0) && (next_q < count_q)) ? S_DIFF : S_DONE;
      S_DIFF:   state_d = S_SQA;
      S_SQA:    state_d = S_SQB;
      S_SQB:    state_d = S_SQC;
      S_SQC:    state_d = S_SQD;
      S_SQD:    state_d = S_ROOT;
      S_ROOT:   if (cnt_q == 5'd31) state_d = S_SNAP;
      S_SNAP:   state_d = (dist_now <= ppf_pkg::SNAP_DIST) ? S_LOOP : S_FACEA;
      S_FACEA:  state_d = S_FACEB;
      S_FACEB:  state_d = (dist_q <= {1'b0, rem_q}) ? S_LOOP : S_PMUL;
      S_PMUL:   state_d = S_PDIVI;
      S_PDIVI:  state_d = S_PDIV;
      S_PDIV:   if (cnt_q == 5'd31) state_d = S_PAPPLY;
      S_PAPPLY: state_d = (axis_q == 2'd2) ? S_LOOP : S_PMUL;
      S_DONE:   if (!out_valid_q || m_axis_tready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      next_q   <= '0;
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
      face_x_q <= '0;
      face_z_q <= '0;
      fvalid_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            fvalid_q <= 1'b0;
            ovf_q    <= 1'b0;
            case (in_cmd)
              ppf_pkg::CMD_START: begin
                count_q <= CW'(1);
                next_q  <= '0;
              end
              ppf_pkg::CMD_APPEND: begin
                if (!count_full) begin
                  count_q <= count_q + CW'(1);
                  if ((count_q == CW'(1)) && (next_q == '0)) next_q <= CW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              ppf_pkg::CMD_SETPOS: begin
                pos_q[0] <= in_wp.x;
                pos_q[1] <= in_wp.y;
                pos_q[2] <= in_wp.z;
              end
              ppf_pkg::CMD_CANCEL: begin
                count_q <= '0;
                next_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SNAP: begin
          if (dist_now <= ppf_pkg::SNAP_DIST) begin
            pos_q[0] <= tgt[0];
            pos_q[1] <= tgt[1];
            pos_q[2] <= tgt[2];
            next_q   <= next_q + CW'(1);
          end
        end
        S_FACEB: begin
          if (face_hit) begin
            face_x_q <= tgt[0];
            face_z_q <= tgt[2];
            fvalid_q <= 1'b1;
          end
          if (dist_q <= {1'b0, rem_q}) begin
            pos_q[0] <= tgt[0];
            pos_q[1] <= tgt[1];
            pos_q[2] <= tgt[2];
            next_q   <= next_q + CW'(1);
          end
        end
        S_PAPPLY: begin
          pos_q[axis_q] <= neg_q[axis_q] ? (pos_q[axis_q] - quo_q) : (pos_q[axis_q] + quo_q);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_BUDGET: rem_q <= prod_q[47:16];
      S_DIFF: begin
        shift_q <= dmag[0][31] | dmag[1][31] | dmag[2][31];
        for (int k = 0; k < 3; k++) begin
          mag_q[k] <= dmag[k][31:0];
          neg_q[k] <= diff[k][32];
          sq_q[k]  <= (dmag[0][31] | dmag[1][31] | dmag[2][31]) ?
                      {1'b0, dmag[k][31:1]} : dmag[k][31:0];
        end
      end
      S_SQB: n_q <= prod_q;
      S_SQC: n_q <= n_q + prod_q;
      S_SQD: begin
        n_q   <= n_q + prod_q;
        r_q   <= '0;
        bit_q <= 64'd1 << 62;
        cnt_q <= '0;
      end
      S_ROOT: begin
        if (n_q >= root_sum) begin
          n_q <= n_q - root_sum;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 5'd1;
      end
      S_SNAP: dist_q <= dist_now;
      S_FACEA: n_q <= prod_q;
      S_FACEB: begin
        if (dist_q <= {1'b0, rem_q}) rem_q <= rem_q - dist_q[31:0];
        axis_q <= 2'd0;
      end
      S_PDIVI: begin
        div_r_q  <= {1'b0, prod_q[63:32]};
        div_lo_q <= prod_q[31:0];
        quo_q    <= '0;
        cnt_q    <= '0;
      end
      S_PDIV: begin
        div_r_q  <= div_ge ? 33'(div_try - {1'b0, dist_q}) : div_try[32:0];
        div_lo_q <= div_lo_q << 1;
        quo_q    <= {quo_q[30:0], div_ge};
        cnt_q    <= cnt_q + 5'd1;
      end
      S_PAPPLY: begin
        if (axis_q == 2'd2) rem_q <= '0;
        axis_q <= axis_q + 2'd1;
      end
      default: ;
    endcase
  end

  // output register
  logic [CW+6:0] next_ext;
  assign next_ext = {7'd0, next_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready_i)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready_i)) begin
      out_data_q <= {6'd0, ovf_q, next_ext[6:0], (next_q < count_q), fvalid_q,
                     face_z_q, face_x_q, pos_q[2], pos_q[1], pos_q[0]};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `PPF_ASSERT(a_next_le_count, next_q <= count_q, "next index beyond waypoint count")
  `PPF_ASSERT(a_count_le_max, count_q <= CW'(MAX_WAYPOINTS), "waypoint count beyond store")
  `PPF_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "output without finish")

endmodule

[rtl/ppf_wp_store.sv]
// ----------------------------------------------------------------------------
// Waypoint store
// Single write port, single registered read port waypoint memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppf_wp_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  ppf_pkg::wp_t  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output ppf_pkg::wp_t  rdata_o
);

  ppf_pkg::wp_t mem [DEPTH];
  ppf_pkg::wp_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
